>>> hdl/tlb_pkg.sv
// Shared types, register indexes and reset values for the touch-triggered LED breathing unit.
package tlb_pkg;

    // Register file layout
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENSITIVITY   = 3'd0,
        REG_FADE_INTERVAL = 3'd1,
        REG_SLEEP_LIMIT   = 3'd2,
        REG_BEAT_COUNT    = 3'd3,
        REG_PWM_TOP       = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [7:0]  SENSITIVITY_RST   = 8'd7;
    localparam logic [7:0]  FADE_INTERVAL_RST = 8'd6;
    localparam logic [15:0] SLEEP_LIMIT_RST   = 16'd2000;
    localparam logic [3:0]  BEAT_COUNT_RST    = 4'd3;
    localparam logic [7:0]  PWM_TOP_RST       = 8'd254;

    // Item kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SENSE = 1'b1;

    // Saturation limits
    localparam logic [7:0]  LEVEL_MAX = 8'hFF;
    localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

endpackage

>>> hdl/tlb_ifs.sv
// Handshake channel interfaces: input items, result items and register writes.
interface tlb_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] sense_count;

    modport source (output valid, output cmd, output sense_count, input ready);
    modport sink   (input valid, input cmd, input sense_count, output ready);
endinterface

interface tlb_result_if;
    logic       valid;
    logic       ready;
    logic       led_on;
    logic [7:0] brightness;
    logic       sleep_request;

    modport source (output valid, output led_on, output brightness, output sleep_request,
                    input ready);
    modport sink   (input valid, input led_on, input brightness, input sleep_request,
                    output ready);
endinterface

interface tlb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tlb_pkg::CFG_INDEX_W-1:0]     index;
    logic [tlb_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/touch_triggered_led_breathing_unit.sv
// Touch-triggered LED breathing unit: input register, single-pass state update, result register.
// An accepted item passes through the input register and the state update into the result register.
// Throughput: one item per cycle while results are taken; the state update is one pass of compares and increments.
// The output register lets the next item enter while a finished result waits to be taken.
// Reset (rst_n low, asynchronous) restores the register defaults and clears all fade state;
// the ramp starts upward.
module touch_triggered_led_breathing_unit (
    input  logic          clk,
    input  logic          rst_n,
    tlb_cfg_if.sink       cfg,
    tlb_item_if.sink      item,
    tlb_result_if.source  result
);
    import tlb_pkg::*;

    // Configuration registers
    logic [7:0]  sensitivity_reg;
    logic [7:0]  fade_interval_reg;
    logic [15:0] sleep_limit_reg;
    logic [3:0]  beat_count_reg;
    logic [7:0]  pwm_top_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_sense_reg;

    // Fade state
    logic [7:0]  pwm_counter_reg,  pwm_counter_next;
    logic [7:0]  level_reg,        level_next;
    logic        ramp_up_reg,      ramp_up_next;
    logic [3:0]  beats_left_reg,   beats_left_next;
    logic [7:0]  step_delay_reg,   step_delay_next;
    logic [15:0] idle_ticks_reg,   idle_ticks_next;
    logic        armed_reg,        armed_next;
    logic [7:0]  last_sample_reg,  last_sample_next;
    logic        led_state_reg,    led_state_next;
    logic        slept_next;

    // Result register
    logic        out_valid_reg;
    logic        out_led_reg;
    logic [7:0]  out_level_reg;
    logic        out_sleep_reg;

    logic        advance;

    // Accept register writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            sensitivity_reg   <= SENSITIVITY_RST;
            fade_interval_reg <= FADE_INTERVAL_RST;
            sleep_limit_reg   <= SLEEP_LIMIT_RST;
            beat_count_reg    <= BEAT_COUNT_RST;
            pwm_top_reg       <= PWM_TOP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_SENSITIVITY:   sensitivity_reg   <= cfg.data[7:0];
                REG_FADE_INTERVAL: fade_interval_reg <= cfg.data[7:0];
                REG_SLEEP_LIMIT:   sleep_limit_reg   <= cfg.data[15:0];
                REG_BEAT_COUNT:    beat_count_reg    <= cfg.data[3:0];
                REG_PWM_TOP:       pwm_top_reg       <= cfg.data[7:0];
                default:           ;
            endcase
        end
    end

    // Move an item from the input register to the result register when there is room
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    // Hold the incoming item
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (item.valid && item.ready)
        begin
            in_cmd_reg   <= item.cmd;
            in_sense_reg <= item.sense_count;
        end
    end

    // Apply one item to the fade state: sense or tick, then fade step, then sleep check
    always_comb begin
        logic [7:0] diff;
        pwm_counter_next = pwm_counter_reg;
        level_next       = level_reg;
        ramp_up_next     = ramp_up_reg;
        beats_left_next  = beats_left_reg;
        step_delay_next  = step_delay_reg;
        idle_ticks_next  = idle_ticks_reg;
        armed_next       = armed_reg;
        last_sample_next = last_sample_reg;
        led_state_next   = led_state_reg;
        slept_next       = 1'b0;
        diff = (in_sense_reg >= last_sample_reg) ? (in_sense_reg - last_sample_reg)
                                                 : (last_sample_reg - in_sense_reg);

        if (in_cmd_reg == CMD_SENSE)
        begin
            // Arm on a steady sample
            if ((diff < sensitivity_reg) && !armed_reg)
            begin
                beats_left_next = beat_count_reg;
                armed_next      = 1'b1;
            end
            last_sample_next = in_sense_reg;
        end
        else
        begin
            // Advance counters and drive the LED
            pwm_counter_next = pwm_counter_reg + 8'd1;
            step_delay_next  = step_delay_reg + 8'd1;
            if (idle_ticks_reg != IDLE_MAX)
            begin
                idle_ticks_next = idle_ticks_reg + 16'd1;
            end
            if (beats_left_reg != 4'd0)
            begin
                if (pwm_counter_next >= pwm_top_reg)
                begin
                    pwm_counter_next = 8'd0;
                end
                led_state_next = (pwm_counter_next < level_reg);
            end
            else
            begin
                pwm_counter_next = 8'd0;
                led_state_next   = 1'b0;
            end
        end

        // Step the brightness ramp
        if ((step_delay_next > fade_interval_reg) && (beats_left_next != 4'd0) && armed_next)
        begin
            if (ramp_up_next)
            begin
                if (level_next != LEVEL_MAX)
                begin
                    level_next = level_next + 8'd1;
                end
            end
            else if (level_next != 8'd0)
            begin
                level_next = level_next - 8'd1;
            end
            if (level_next >= pwm_top_reg)
            begin
                ramp_up_next = 1'b0;
            end
            if (level_next == 8'd0)
            begin
                ramp_up_next    = 1'b1;
                beats_left_next = beats_left_next - 4'd1;
            end
            step_delay_next = 8'd0;
            idle_ticks_next = 16'd0;
        end

        // Drop to sleep once idle with no beats left
        if ((idle_ticks_next >= sleep_limit_reg) && (beats_left_next == 4'd0))
        begin
            beats_left_next  = 4'd0;
            led_state_next   = 1'b0;
            level_next       = 8'd0;
            pwm_counter_next = 8'd0;
            step_delay_next  = 8'd0;
            idle_ticks_next  = 16'd0;
            armed_next       = 1'b0;
            ramp_up_next     = 1'b1;
            slept_next       = 1'b1;
        end
    end

    // Commit the fade state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pwm_counter_reg <= 8'd0;
            level_reg       <= 8'd0;
            ramp_up_reg     <= 1'b1;
            beats_left_reg  <= 4'd0;
            step_delay_reg  <= 8'd0;
            idle_ticks_reg  <= 16'd0;
            armed_reg       <= 1'b0;
            last_sample_reg <= 8'd0;
            led_state_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pwm_counter_reg <= pwm_counter_next;
            level_reg       <= level_next;
            ramp_up_reg     <= ramp_up_next;
            beats_left_reg  <= beats_left_next;
            step_delay_reg  <= step_delay_next;
            idle_ticks_reg  <= idle_ticks_next;
            armed_reg       <= armed_next;
            last_sample_reg <= last_sample_next;
            led_state_reg   <= led_state_next;
        end
    end

    // Hold the result item until taken
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance)
        begin
            out_led_reg   <= led_state_next;
            out_level_reg <= level_next;
            out_sleep_reg <= slept_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.led_on        = out_led_reg;
    assign result.brightness    = out_level_reg;
    assign result.sleep_request = out_sleep_reg;

    // A sleep result always shows a dark LED at zero brightness
    a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sleep_reg) |-> (!out_led_reg && (out_level_reg == 8'd0)))
        else $error("sleep result with LED lit or nonzero brightness");

    // Without arming the ramp is at rest
    a_disarmed_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> ((level_reg == 8'd0) && ramp_up_reg && (beats_left_reg == 4'd0)))
        else $error("fade state active while disarmed");

    // An item moved on always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item lost before the result register");

endmodule
